@@ src/sfs_pkg.sv @@
// shared types and constants of the sprite frame sequencer
// no dependencies; used by every module in src
package sfs_pkg;

  localparam int unsigned NumFrames = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned DurW      = 16;
  localparam int unsigned FrameW    = 3;
  localparam int unsigned TimerW    = DurW + 1;

  localparam logic [DurW-1:0]   DefaultDuration = 16'd100;
  localparam logic [FrameW-1:0] DefaultCount    = 3'd1;
  localparam logic [FrameW-1:0] MaxCount        = 3'd6;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLoopMode   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDuration0  = 3'd2;

  // opcodes
  localparam logic OpTick    = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [DurW-1:0] elapsed_ms;
  } sfs_in_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_index;
    logic [DurW-1:0]   time_in_frame;
  } sfs_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted beat
    logic load;     // add elapsed time or restart, clamp frame
    logic step;     // subtract one duration and advance
    logic finish;   // move result into the output register
  } sfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic expired;  // timer at or above current duration
  } sfs_status_t;

endpackage

@@ src/sfs_ctrl.sv @@
// controller of the sprite frame sequencer: sequences capture, load,
// subtract loop and output handoff; depends on sfs_pkg
module sfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sfs_pkg::sfs_status_t status_i,
  output sfs_pkg::sfs_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StIter = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d    = StIter;
      end
      StIter: begin
        if (status_i.expired) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/sfs_datapath.sv @@
// datapath of the sprite frame sequencer: configuration registers, frame
// and timer state, duration lookup and subtractor; depends on sfs_pkg
module sfs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfs_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [sfs_pkg::DurW-1:0]             cfg_wdata_i,
  input  sfs_pkg::sfs_in_t                     in_data_i,
  input  sfs_pkg::sfs_cmd_t                    cmd_i,
  output sfs_pkg::sfs_status_t                 status_o,
  output sfs_pkg::sfs_out_t                    out_data_o
);

  logic [sfs_pkg::FrameW-1:0] count_q;
  logic                       loop_q;
  logic [sfs_pkg::DurW-1:0]   dur_q [sfs_pkg::NumFrames];

  logic [sfs_pkg::FrameW-1:0] frame_q, frame_d;
  logic [sfs_pkg::TimerW-1:0] timer_q, timer_d;
  logic                       restart_q;
  logic [sfs_pkg::DurW-1:0]   delta_q;
  sfs_pkg::sfs_out_t          out_q;

  logic [sfs_pkg::FrameW-1:0] count_eff;
  logic [sfs_pkg::DurW-1:0]   dur_raw, dur;
  logic [sfs_pkg::FrameW-1:0] frame_nxt;
  logic [sfs_pkg::TimerW-1:0] timer_sub;

  // register writes; every 3-bit index names a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= sfs_pkg::DefaultCount;
      loop_q  <= 1'b1;
      for (int i = 0; i < sfs_pkg::NumFrames; i++) begin
        dur_q[i] <= sfs_pkg::DefaultDuration;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sfs_pkg::CfgFrameCount) begin
        count_q <= cfg_wdata_i[sfs_pkg::FrameW-1:0];
      end
      if (cfg_idx_i == sfs_pkg::CfgLoopMode) begin
        loop_q <= cfg_wdata_i[0];
      end
      for (int i = 0; i < sfs_pkg::NumFrames; i++) begin
        if (cfg_idx_i == sfs_pkg::CfgDuration0 + sfs_pkg::CfgIdxW'(i)) begin
          dur_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  // zero acts as one frame, seven as six
  always_comb begin
    if (count_q == '0) begin
      count_eff = sfs_pkg::DefaultCount;
    end else if (count_q > sfs_pkg::MaxCount) begin
      count_eff = sfs_pkg::MaxCount;
    end else begin
      count_eff = count_q;
    end
  end

  always_comb begin
    case (frame_q)
      3'd0:    dur_raw = dur_q[0];
      3'd1:    dur_raw = dur_q[1];
      3'd2:    dur_raw = dur_q[2];
      3'd3:    dur_raw = dur_q[3];
      3'd4:    dur_raw = dur_q[4];
      default: dur_raw = dur_q[5];
    endcase
    dur = (dur_raw == '0) ? sfs_pkg::DefaultDuration : dur_raw;
  end

  assign status_o.expired = (timer_q >= {1'b0, dur});
  assign timer_sub        = timer_q - {1'b0, dur};
  assign frame_nxt        = frame_q + 3'd1;

  always_comb begin
    frame_d = frame_q;
    timer_d = timer_q;
    if (cmd_i.load) begin
      if (restart_q == sfs_pkg::OpRestart) begin
        frame_d = '0;
        timer_d = '0;
      end else begin
        if (frame_q >= count_eff) begin
          frame_d = count_eff - 3'd1;
        end
        timer_d = timer_q + {1'b0, delta_q};
      end
    end else if (cmd_i.step) begin
      if (frame_nxt >= count_eff) begin
        if (loop_q) begin
          frame_d = '0;
          timer_d = timer_sub;
        end else begin
          // hold the last frame, timer cleared ends the loop
          frame_d = count_eff - 3'd1;
          timer_d = '0;
        end
      end else begin
        frame_d = frame_nxt;
        timer_d = timer_sub;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      timer_q <= '0;
    end else begin
      frame_q <= frame_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      restart_q <= in_data_i.opcode;
      delta_q   <= in_data_i.elapsed_ms;
    end
    if (cmd_i.finish) begin
      out_q.frame_index   <= frame_q;
      out_q.time_in_frame <= timer_q[sfs_pkg::DurW-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule

@@ src/sprite_frame_sequencer.sv @@
// top level of the sprite frame sequencer: controller plus datapath
// depends on sfs_pkg, sfs_ctrl and sfs_datapath
//
// Sprite animation frame sequencer. Each input beat is a tick (adds
// elapsed_ms to the in-frame timer) or a restart (frame and timer to zero),
// and each gives exactly one output beat with the frame index and the time
// spent in it afterwards. An accepted beat is captured, then loaded, then the
// iterative subtract loop retires one frame duration per cycle until the
// timer is below the current duration, and then the result moves into the
// output register; a restart skips the loop. The loop can be long when
// durations are short relative to the elapsed time. The next beat can be
// taken in the cycle after the result is registered. One item is in work at a
// time: in_stall_o is high from acceptance until the result is in the output
// register, and a finished result that is not yet taken holds the next item
// in its last cycle. Configuration registers are indexed as listed (frame
// count, loop mode, six durations); write them only while idle and issue a
// restart afterward. A zero duration acts as 100 ms, a frame count of zero
// acts as one and seven as six.
module sprite_frame_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [sfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfs_pkg::DurW-1:0]    cfg_wdata_i,
  // input beats
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sfs_pkg::sfs_in_t            in_data_i,
  // output beats
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sfs_pkg::sfs_out_t           out_data_o
);

  sfs_pkg::sfs_cmd_t    cmd;
  sfs_pkg::sfs_status_t status;

  // controller: idle, load, iterate; owns the output valid flag
  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: registers, frame/timer state and the output register
  sfs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// testbench for sprite_frame_sequencer: directed script, then randomized config phases
// depends on sfs_pkg and the sprite_frame_sequencer rtl from src
module tb;
  import sfs_pkg::*;

  // one tick with 1 ms frames runs its subtract loop once per elapsed ms before
  // its result, so the hang limit sits well above the longest such run
  localparam int unsigned HangLimit  = 400000;
  localparam int unsigned TotalBeats = 1920;
  localparam int unsigned NumRegs    = NumFrames + 2;

  typedef enum logic {RowWrite, RowBeat} row_kind_e;

  // one line of the directed script: a register write or an input beat,
  // with the result typed in where it is obvious
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [DurW-1:0]    wdata;
    sfs_in_t            beat;
    logic               typed;
    sfs_out_t           want;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [DurW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  sfs_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sfs_out_t           out_data_o;

  // shadow of the animation registers and state
  logic [FrameW-1:0] cfg_count;
  logic              cfg_loop;
  logic [DurW-1:0]   cfg_dur [NumFrames];
  logic [FrameW-1:0] cur_frame;
  logic [DurW-1:0]   shadow_ms;

  script_row_t script_q[$];
  sfs_out_t    pending_frames[$];  // expected frame/timer results, oldest first
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet      = 0;
  bit          calm       = 1'b0;  // no idling on either side this phase

  sprite_frame_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // zero duration shows for the default time
  function automatic logic [DurW-1:0] frame_len(input logic [FrameW-1:0] f);
    return (cfg_dur[f] == '0) ? DefaultDuration : cfg_dur[f];
  endfunction

  // count of zero acts as one, seven acts as six
  function automatic logic [FrameW-1:0] live_count();
    if (cfg_count == '0) return 3'd1;
    if (cfg_count > MaxCount) return MaxCount;
    return cfg_count;
  endfunction

  // steps the shadow animation by one beat and returns the frame and timer after it
  function automatic sfs_out_t advance_animation(input sfs_in_t beat);
    logic [FrameW-1:0] n;
    logic [TimerW-1:0] acc;
    logic [DurW-1:0]   dur;
    sfs_out_t          res;
    if (beat.opcode == OpRestart) begin
      cur_frame = '0;
      shadow_ms = '0;
    end else begin
      n = live_count();
      // count lowered without a restart: clamp to the last frame first
      if (cur_frame >= n) cur_frame = n - 3'd1;
      // 17-bit sum, so a leftover timer plus a full tick never wraps
      acc = TimerW'(shadow_ms) + TimerW'(beat.elapsed_ms);
      dur = frame_len(cur_frame);
      while (acc >= TimerW'(dur)) begin
        acc = acc - TimerW'(dur);
        if (cur_frame + 3'd1 >= n) begin
          if (cfg_loop) begin
            cur_frame = '0;
          end else begin
            // one-shot: park on the last frame with the timer cleared
            cur_frame = n - 3'd1;
            acc       = '0;
            break;
          end
        end else begin
          cur_frame = cur_frame + 3'd1;
        end
        dur = frame_len(cur_frame);
      end
      shadow_ms = acc[DurW-1:0];
    end
    res.frame_index   = cur_frame;
    res.time_in_frame = shadow_ms;
    return res;
  endfunction

  function automatic void add_write(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    script_row_t row;
    row       = '0;
    row.kind  = RowWrite;
    row.idx   = idx;
    row.wdata = val;
    script_q.push_back(row);
  endfunction

  function automatic void add_beat(input logic op, input logic [DurW-1:0] ms,
                                   input logic typed, input logic [FrameW-1:0] f,
                                   input logic [DurW-1:0] t);
    script_row_t row;
    row                    = '0;
    row.kind               = RowBeat;
    row.beat.opcode        = op;
    row.beat.elapsed_ms    = ms;
    row.typed              = typed;
    row.want.frame_index   = f;
    row.want.time_in_frame = t;
    script_q.push_back(row);
  endfunction

  // one register write per clock; the caller drops the enable after the batch
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgFrameCount: cfg_count = val[FrameW-1:0];
      CfgLoopMode:   cfg_loop  = val[0];
      default:       cfg_dur[idx - CfgDuration0] = val;
    endcase
    @(posedge clk_i);
  endtask

  // presents one beat after a random gap and returns at the edge that takes it;
  // valid is left high so a back-to-back beat needs no extra assignment
  task automatic send_beat(input sfs_in_t beat, input logic typed, input sfs_out_t want);
    int unsigned gap;
    sfs_out_t    guess;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    guess = advance_animation(beat);
    pending_frames.push_back(typed ? want : guess);
    beats_sent++;
  endtask

  // every beat gives a result, so an empty queue means the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // main stimulus
  initial begin
    script_row_t       row;
    bit                writing;
    int unsigned       shortest;
    int unsigned       spread;
    int unsigned       phase_len;
    int unsigned       style;
    logic [FrameW-1:0] n;
    logic [DurW-1:0]   val;
    sfs_in_t           beat;

    cfg_count = DefaultCount;
    cfg_loop  = 1'b1;
    for (int f = 0; f < NumFrames; f++) cfg_dur[f] = DefaultDuration;
    cur_frame = '0;
    shadow_ms = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: one 100 ms frame, looping
    add_beat(OpTick, 16'd0, 1'b1, 3'd0, 16'd0);
    add_beat(OpTick, 16'd99, 1'b1, 3'd0, 16'd99);
    add_beat(OpTick, 16'd1, 1'b1, 3'd0, 16'd0);          // single frame wraps onto itself
    add_beat(OpTick, 16'hFFFF, 1'b1, 3'd0, 16'd35);      // 655 wraps, 35 left
    add_beat(OpRestart, 16'hFFFF, 1'b1, 3'd0, 16'd0);    // elapsed ignored on restart
    // count of seven acts as six, one-shot, zero duration on frame 0
    add_write(CfgFrameCount, 16'd7);
    add_write(CfgLoopMode, 16'd0);
    add_write(CfgDuration0, 16'd0);
    add_write(CfgDuration0 + 3'd1, 16'd1);
    add_write(CfgDuration0 + 3'd2, 16'hFFFF);
    add_write(CfgDuration0 + 3'd3, 16'd2);
    add_write(CfgDuration0 + 3'd4, 16'd3);
    add_write(CfgDuration0 + 3'd5, 16'd5);
    add_beat(OpRestart, 16'd0, 1'b1, 3'd0, 16'd0);
    add_beat(OpTick, 16'd99, 1'b1, 3'd0, 16'd99);
    add_beat(OpTick, 16'd1, 1'b1, 3'd1, 16'd0);
    add_beat(OpTick, 16'd1, 1'b1, 3'd2, 16'd0);
    add_beat(OpTick, 16'hFFFE, 1'b1, 3'd2, 16'hFFFE);    // largest timer value
    add_beat(OpTick, 16'hFFFF, 1'b1, 3'd5, 16'd0);       // runs off the end and holds
    add_beat(OpTick, 16'd4, 1'b0, 3'd0, 16'd0);
    add_beat(OpTick, 16'hFFFF, 1'b1, 3'd5, 16'd0);
    // count of zero with no restart: frame 5 is clamped back to frame 0
    add_write(CfgFrameCount, 16'd0);
    add_beat(OpTick, 16'd0, 1'b1, 3'd0, 16'd0);
    add_write(CfgFrameCount, 16'd6);
    add_write(CfgLoopMode, 16'd1);
    add_write(CfgDuration0, 16'hFFFF);
    add_beat(OpTick, 16'hFFFE, 1'b1, 3'd0, 16'hFFFE);
    // shrink every frame to 1 ms under a full timer: longest subtract run
    for (int f = 0; f < NumFrames; f++) add_write(CfgDuration0 + f[CfgIdxW-1:0], 16'd1);
    add_beat(OpTick, 16'hFFFF, 1'b0, 3'd0, 16'd0);
    add_beat(OpRestart, 16'h8000, 1'b1, 3'd0, 16'd0);
    add_write(CfgLoopMode, 16'd0);
    add_write(CfgFrameCount, 16'd3);
    add_beat(OpTick, 16'hFFFF, 1'b1, 3'd2, 16'd0);
    add_beat(OpTick, 16'd0, 1'b1, 3'd2, 16'd0);
    add_beat(OpRestart, 16'h5555, 1'b1, 3'd0, 16'd0);

    writing = 1'b0;
    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.kind == RowWrite) begin
        if (!writing) settle();
        writing = 1'b1;
        write_reg(row.idx, row.wdata);
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        send_beat(row.beat, row.typed, row.want);
      end
    end

    // random phases: new settings, usually a restart, then a run of ticks
    while (beats_sent < TotalBeats) begin
      settle();
      calm  = ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 3);
      for (int r = 0; r < NumRegs; r++) begin
        if ($urandom_range(0, 3) != 0) begin
          if (r < CfgDuration0) begin
            // count and mode take the low bits of a full random word
            val = DurW'($urandom_range(0, 65535));
          end else begin
            case (style)
              0:       val = DurW'($urandom_range(0, 16));
              1:       val = DurW'($urandom_range(0, 1000));
              2:       val = DurW'($urandom_range(0, 65535));
              default: begin
                case ($urandom_range(0, 3))
                  0:       val = 16'd0;
                  1:       val = 16'd1;
                  2:       val = 16'hFFFF;
                  default: val = DurW'($urandom_range(0, 65535));
                endcase
              end
            endcase
          end
          write_reg(r[CfgIdxW-1:0], val);
        end
      end
      cfg_we_i <= 1'b0;

      // keep the subtract loop short: tick size scales with the shortest frame
      n        = live_count();
      shortest = 65535;
      for (int f = 0; f < n; f++) begin
        if (frame_len(f[FrameW-1:0]) < shortest) shortest = 32'(frame_len(f[FrameW-1:0]));
      end

      beat.opcode     = OpRestart;
      beat.elapsed_ms = DurW'($urandom_range(0, 65535));
      // a skipped restart leaves the old frame and timer to be worked off
      if (shortest < 32 || $urandom_range(0, 3) != 0) send_beat(beat, 1'b0, '0);

      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        if ($urandom_range(0, 19) == 0) begin
          beat.opcode     = OpRestart;
          beat.elapsed_ms = DurW'($urandom_range(0, 65535));
        end else begin
          beat.opcode = OpTick;
          if (shortest >= 64 && $urandom_range(0, 7) == 0) spread = 65535;
          else spread = shortest * $urandom_range(1, 8);
          if (spread > 65535) spread = 65535;
          beat.elapsed_ms = DurW'($urandom_range(0, spread));
        end
        send_beat(beat, 1'b0, '0);
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side: random stall before each beat, none in calm phases
  initial begin
    int unsigned hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    sfs_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_frames.size() == 0) begin
        $error("result with nothing pending: frame_index %0d time_in_frame %0d",
               out_data_o.frame_index, out_data_o.time_in_frame);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (out_data_o.frame_index !== want.frame_index) begin
          $error("frame_index: expected %0d, got %0d",
                 want.frame_index, out_data_o.frame_index);
          mismatches++;
        end
        if (out_data_o.time_in_frame !== want.time_in_frame) begin
          $error("time_in_frame: expected %0d, got %0d",
                 want.time_in_frame, out_data_o.time_in_frame);
          mismatches++;
        end
      end
    end
  end

  // hang detection: cycles in a row with no beat and no register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        cfg_we_i) begin
      quiet <= 0;
    end else if (quiet == HangLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

@@ files.f @@
src/sfs_pkg.sv
src/sfs_ctrl.sv
src/sfs_datapath.sv
src/sprite_frame_sequencer.sv
sim/tb.sv
